@@ rtl/lap3_pkg.sv @@
// Shared constants, codes and types of the 3x3 Laplacian edge filter.
`default_nettype none

package lap3_pkg;

    localparam int MaxWidth    = 1024;
    localparam int MaxHeight   = 1024;
    localparam int MaxChannels = 4;
    localparam int KernelSize  = 3;
    localparam int StoreDepth  = MaxWidth * MaxChannels;

    localparam int ColW   = $clog2(MaxWidth);
    localparam int RowW   = $clog2(MaxHeight + 2);
    localparam int ChW    = $clog2(MaxChannels);
    localparam int AddrW  = $clog2(StoreDepth);
    localparam int CfgW   = 11;
    localparam int CfgIdxW = 2;
    localparam int PixW   = 8;
    localparam int SumW   = 12;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_CHANNEL_COUNT
    } lap3_cfg_idx_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_FLUSH  = 1'b1
    } lap3_req_t;

    // one column of three rows, top row at index 0
    typedef logic [KernelSize-1:0][PixW-1:0] lap3_col_t;
    // window[row][column], column 2 is the newest
    typedef logic [KernelSize-1:0][KernelSize-1:0][PixW-1:0] lap3_win_t;

    // both line stores share one address, so one word carries both bytes
    typedef struct packed {
        logic [PixW-1:0] upper;
        logic [PixW-1:0] middle;
    } lap3_pair_t;

    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr;
        lap3_pair_t       data;
    } lap3_store_wr_t;

endpackage

`default_nettype wire

@@ rtl/lap3_ifs.sv @@
// Stream and configuration channel interfaces of the edge filter.
`default_nettype none

interface lap3_in_if import lap3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            req_type;
    logic [PixW-1:0] sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink (input valid, input req_type, input sample, output ready);
endinterface

interface lap3_out_if import lap3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [PixW-1:0] filtered;
    logic            frame_end;

    modport source (output valid, output filtered, output frame_end, input ready);
    modport sink (input valid, input filtered, input frame_end, output ready);
endinterface

interface lap3_cfg_if import lap3_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/laplacian_3x3_edge_filter.sv @@
// Streaming 3x3 Laplacian edge filter: top level with counters, window and output word.
// The result for a byte leaves (image_width + 1) * channel_count words later, through the
//   stage register and then the output register. The line-store memory is read once and
//   written once per word. Throughput: one word per cycle while the output is not stalled.
// Reset: rst_n clears counters and valid flags and sets 1024 x 1024, one channel;
//   the line stores are not cleared, rows not yet written in a frame are read as zero.
`default_nettype none

module laplacian_3x3_edge_filter import lap3_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lap3_in_if.sink     pixel_in,
    lap3_out_if.source  pixel_out,
    lap3_cfg_if.sink    cfg
);

    // configuration, held clamped
    logic [ColW-1:0] w_m1_reg;
    logic [RowW-1:0] h_reg;
    logic [ChW-1:0]  ch_m1_reg;

    // position of the next incoming word
    logic [ChW-1:0]   c_reg;
    logic [ColW-1:0]  x_reg;
    logic [RowW-1:0]  y_reg;
    logic [AddrW-1:0] addr_reg;

    // stage register
    logic             s1_valid_reg;
    logic [AddrW-1:0] s1_addr_reg;
    logic [ChW-1:0]   s1_c_reg;
    logic             s1_first_reg;
    logic             s1_use_up_reg;
    logic             s1_use_mid_reg;
    logic [PixW-1:0]  s1_val_reg;
    logic             s1_emit_reg;
    logic             s1_fe_reg;

    // output register
    logic            out_valid_reg;
    logic [PixW-1:0] out_filtered_reg;
    logic            out_fe_reg;

    lap3_win_t win_reg [MaxChannels];

    logic            cfg_wr;
    logic            acc;
    logic            out_free;
    logic            s1_adv;
    logic            is_flush;
    logic            drop;
    logic            last_c;
    logic            last_x;
    logic            s0_emit;
    logic            s0_fe;
    logic            s0_zero;
    logic [CfgW-1:0] cfg_w_clamped;
    logic [CfgW-1:0] cfg_h_clamped;
    logic [2:0]      cfg_ch_clamped;

    lap3_pair_t      rd;
    lap3_store_wr_t  st_wr;
    lap3_col_t       col;
    lap3_win_t       win_next;
    logic [PixW-1:0] result;

    assign cfg_wr    = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    assign acc      = pixel_in.valid && pixel_in.ready;
    assign out_free = !out_valid_reg || pixel_out.ready;
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || out_free);
    assign pixel_in.ready = !s1_valid_reg || s1_adv;

    assign is_flush = (pixel_in.req_type == REQ_FLUSH);
    assign drop     = is_flush && c_reg == '0 && x_reg == '0 && y_reg == '0;
    assign last_c   = (c_reg == ch_m1_reg);
    assign last_x   = (x_reg == w_m1_reg);
    assign s0_zero  = is_flush || (y_reg >= h_reg);
    assign s0_emit  = (x_reg == '0) ? (y_reg >= RowW'(2)) : (y_reg != '0);
    // last result: centre at the bottom-right pixel, seen on the first column two rows on
    assign s0_fe    = s0_emit && x_reg == '0 && last_c
                      && ({1'b0, y_reg} == ({1'b0, h_reg} + (RowW+1)'(1)));

    always_comb
    begin
        cfg_w_clamped = cfg.data;
        if (cfg.data == '0)
        begin
            cfg_w_clamped = CfgW'(1);
        end
        else if (cfg.data > CfgW'(MaxWidth))
        begin
            cfg_w_clamped = CfgW'(MaxWidth);
        end
        cfg_h_clamped = cfg.data;
        if (cfg.data == '0)
        begin
            cfg_h_clamped = CfgW'(1);
        end
        else if (cfg.data > CfgW'(MaxHeight))
        begin
            cfg_h_clamped = CfgW'(MaxHeight);
        end
        cfg_ch_clamped = cfg.data[2:0];
        if (cfg.data[2:0] == '0)
        begin
            cfg_ch_clamped = 3'd1;
        end
        else if (cfg.data[2:0] > 3'(MaxChannels))
        begin
            cfg_ch_clamped = 3'(MaxChannels);
        end
    end

    // configuration and input position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg  <= ColW'(MaxWidth - 1);
            h_reg     <= RowW'(MaxHeight);
            ch_m1_reg <= '0;
            c_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            addr_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                CFG_IMAGE_WIDTH:
                begin
                    w_m1_reg <= ColW'(cfg_w_clamped - CfgW'(1));
                end
                CFG_IMAGE_HEIGHT:
                begin
                    h_reg <= RowW'(cfg_h_clamped);
                end
                CFG_CHANNEL_COUNT:
                begin
                    ch_m1_reg <= ChW'(cfg_ch_clamped - 3'd1);
                end
                default:
                begin
                end
            endcase
            if (cfg.index == CFG_IMAGE_WIDTH || cfg.index == CFG_IMAGE_HEIGHT
                || cfg.index == CFG_CHANNEL_COUNT)
            begin
                c_reg    <= '0;
                x_reg    <= '0;
                y_reg    <= '0;
                addr_reg <= '0;
            end
        end
        else if (acc && !drop)
        begin
            if (s0_fe)
            begin
                c_reg    <= '0;
                x_reg    <= '0;
                y_reg    <= '0;
                addr_reg <= '0;
            end
            else if (last_c)
            begin
                c_reg <= '0;
                if (last_x)
                begin
                    x_reg    <= '0;
                    y_reg    <= y_reg + RowW'(1);
                    addr_reg <= '0;
                end
                else
                begin
                    x_reg    <= x_reg + ColW'(1);
                    addr_reg <= addr_reg + AddrW'(1);
                end
            end
            else
            begin
                c_reg    <= c_reg + ChW'(1);
                addr_reg <= addr_reg + AddrW'(1);
            end
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                s1_valid_reg <= !drop;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv && s1_emit_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_addr_reg    <= addr_reg;
            s1_c_reg       <= c_reg;
            s1_first_reg   <= (x_reg == '0);
            s1_use_up_reg  <= (y_reg >= RowW'(2));
            s1_use_mid_reg <= (y_reg != '0) && (y_reg <= h_reg);
            s1_val_reg     <= s0_zero ? '0 : pixel_in.sample;
            s1_emit_reg    <= s0_emit;
            s1_fe_reg      <= s0_fe;
        end
        if (s1_adv)
        begin
            win_reg[s1_c_reg] <= win_next;
        end
        if (s1_adv && s1_emit_reg)
        begin
            out_filtered_reg <= result;
            out_fe_reg       <= s1_fe_reg;
        end
    end

    assign col[0] = s1_use_up_reg ? rd.upper : '0;
    assign col[1] = s1_use_mid_reg ? rd.middle : '0;
    assign col[2] = s1_val_reg;

    assign st_wr.en          = s1_adv;
    assign st_wr.addr        = s1_addr_reg;
    assign st_wr.data.upper  = col[1];
    assign st_wr.data.middle = col[2];

    lap3_line_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ren   (acc && !drop),
        .raddr (addr_reg),
        .wr    (st_wr),
        .rdata (rd)
    );

    lap3_kernel u_kernel (
        .win       (win_reg[s1_c_reg]),
        .col       (col),
        .first_col (s1_first_reg),
        .win_next  (win_next),
        .result    (result)
    );

    assign pixel_out.valid     = out_valid_reg;
    assign pixel_out.filtered  = out_filtered_reg;
    assign pixel_out.frame_end = out_fe_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (c_reg <= ch_m1_reg) && (x_reg <= w_m1_reg))
        else $error("input position beyond configured row");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, y_reg} <= ({1'b0, h_reg} + (RowW+1)'(1)))
        else $error("input row beyond frame drain");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !drop && s0_fe && !cfg_wr)
        |=> (c_reg == '0 && x_reg == '0 && y_reg == '0 && addr_reg == '0))
        else $error("frame end did not restart position");

    a_addr_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        (x_reg == '0 && c_reg == '0) |-> (addr_reg == '0))
        else $error("store address out of step with position");

endmodule

`default_nettype wire

@@ rtl/lap3_line_store.sv @@
// Two line stores in one memory, registered read with write-through bypass.
`default_nettype none

module lap3_line_store import lap3_pkg::*; (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           ren,
    input  wire logic [AddrW-1:0] raddr,
    input  wire lap3_store_wr_t wr,
    output lap3_pair_t          rdata
);

    lap3_pair_t mem [StoreDepth];
    lap3_pair_t q_reg;
    lap3_pair_t fwd_data_reg;
    logic       fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (ren)
        begin
            q_reg        <= mem[raddr];
            fwd_data_reg <= wr.data;
        end
    end

    // same-cycle read of the word being written (as in a row of one word)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (ren)
        begin
            fwd_reg <= wr.en && (wr.addr == raddr);
        end
    end

    assign rdata = fwd_reg ? fwd_data_reg : q_reg;

endmodule

`default_nettype wire

@@ rtl/lap3_kernel.sv @@
// Window shift, 8-neighbour Laplacian sum and clamp for one channel.
`default_nettype none

module lap3_kernel import lap3_pkg::*; (
    input  wire lap3_win_t       win,
    input  wire lap3_col_t       col,
    input  wire logic            first_col,
    output lap3_win_t            win_next,
    output logic [PixW-1:0]      result
);

    lap3_win_t              shifted;
    logic [SumW-2:0]        nb_sum;
    logic [SumW-2:0]        centre8;
    logic signed [SumW-1:0] sum;

    always_comb
    begin
        for (int r = 0; r < KernelSize; r++)
        begin
            shifted[r][0] = win[r][1];
            shifted[r][1] = win[r][2];
            // right neighbour of the last column lies outside the image
            shifted[r][2] = first_col ? '0 : col[r];
        end
    end

    always_comb
    begin
        nb_sum = '0;
        for (int r = 0; r < KernelSize; r++)
        begin
            for (int k = 0; k < KernelSize; k++)
            begin
                if (!(r == 1 && k == 1))
                begin
                    nb_sum = nb_sum + (SumW-1)'(shifted[r][k]);
                end
            end
        end
        centre8 = {shifted[1][1], 3'b000};
        sum     = signed'({1'b0, centre8}) - signed'({1'b0, nb_sum});
        if (sum[SumW-1])
        begin
            result = '0;
        end
        else if (sum[SumW-2:PixW] != '0)
        begin
            result = '1;
        end
        else
        begin
            result = sum[PixW-1:0];
        end
    end

    // a new row starts with the left neighbours outside the image
    always_comb
    begin
        for (int r = 0; r < KernelSize; r++)
        begin
            win_next[r][0] = first_col ? '0 : shifted[r][0];
            win_next[r][1] = first_col ? '0 : shifted[r][1];
            win_next[r][2] = first_col ? col[r] : shifted[r][2];
        end
    end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the streaming 3x3 Laplacian edge filter with a bit-exact predictor.
module testbench;
    import lap3_pkg::*;

    localparam int HalfPeriod   = 6;
    localparam int ResetCycles  = 7;
    localparam int SettleCycles = 8;
    localparam int RandomWords  = 250;
    localparam int LimitCycles  = 2500000;
    localparam int MaxReports   = 100;
    localparam int WinSize      = KernelSize * KernelSize;
    localparam int CentreTap    = WinSize / 2;

    typedef struct packed {
        logic [PixW-1:0] filtered;
        logic            frame_end;
    } lap_result_t;

    // Predicts the filtered bytes and frame_end flags, and checks the stream against them.
    class edge_scoreboard;
        logic [PixW-1:0] upper_row [StoreDepth];
        logic [PixW-1:0] middle_row [StoreDepth];
        logic [PixW-1:0] window [MaxChannels][WinSize];
        int col_pos, row_pos, chan_pos, out_pos;
        int width_reg, height_reg, chans_reg;
        lap_result_t expected_filtered [$];
        int errors, checked, frames_done, words_in, flush_words, writes;
        int pinned_low, pinned_high;

        function new();
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            width_reg  = MaxWidth;
            height_reg = MaxHeight;
            chans_reg  = 1;
            restart();
        endfunction

        function void restart();
            col_pos  = 0;
            row_pos  = 0;
            chan_pos = 0;
            out_pos  = 0;
            foreach (window[i, j])
                window[i][j] = '0;
        endfunction

        function int clamp_to(int v, int hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int pending();
            return expected_filtered.size();
        endfunction

        function bit at_frame_start();
            return chan_pos == 0 && col_pos == 0 && row_pos == 0;
        endfunction

        function bit in_image();
            return row_pos < clamp_to(height_reg, MaxHeight);
        endfunction

        function void load_register(lap3_cfg_idx_t idx, logic [CfgW-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:   width_reg = value;
                CFG_IMAGE_HEIGHT:  height_reg = value;
                CFG_CHANNEL_COUNT: chans_reg = value[2:0];
                default:           return;
            endcase
            writes++;
            restart();
        endfunction

        function void take_word(lap3_req_t req, logic [PixW-1:0] smp);
            int w, h, ch, c, x, y, addr, centre, sum;
            logic [PixW-1:0] val;
            logic [PixW-1:0] column [KernelSize];
            bit emit;
            lap_result_t res;
            w  = clamp_to(width_reg, MaxWidth);
            h  = clamp_to(height_reg, MaxHeight);
            ch = clamp_to(chans_reg, MaxChannels);
            words_in++;
            if (req == REQ_FLUSH)
                flush_words++;
            if (chan_pos >= ch || col_pos >= w || row_pos > h + 1)
                restart();
            c = chan_pos;
            x = col_pos;
            y = row_pos;
            // a flush before any word of the frame is dropped
            if (req == REQ_FLUSH && c == 0 && x == 0 && y == 0)
                return;
            val = (req == REQ_FLUSH || y >= h) ? '0 : smp;
            addr = x * ch + c;
            if (addr >= StoreDepth)
                addr = 0;
            column[0] = (y >= 2 && y - 2 < h) ? upper_row[addr] : '0;
            column[1] = (y >= 1 && y - 1 < h) ? middle_row[addr] : '0;
            column[2] = val;
            upper_row[addr]  = column[1];
            middle_row[addr] = column[2];
            for (int r = 0; r < KernelSize; r++)
            begin
                window[c][r*KernelSize]     = window[c][r*KernelSize + 1];
                window[c][r*KernelSize + 1] = window[c][r*KernelSize + 2];
                window[c][r*KernelSize + 2] = (x == 0) ? '0 : column[r];
            end
            // first column of a row closes the previous row's last pixel
            centre = (x == 0) ? y - 2 : y - 1;
            emit = centre >= 0;
            sum = 0;
            if (emit)
            begin
                for (int k = 0; k < WinSize; k++)
                begin
                    if (k == CentreTap)
                        sum += 8 * int'(window[c][k]);
                    else
                        sum -= int'(window[c][k]);
                end
                if (sum < 0)
                    sum = 0;
                if (sum > 255)
                    sum = 255;
            end
            if (x == 0)
            begin
                for (int r = 0; r < KernelSize; r++)
                begin
                    window[c][r*KernelSize]     = '0;
                    window[c][r*KernelSize + 1] = '0;
                    window[c][r*KernelSize + 2] = column[r];
                end
            end
            c++;
            if (c >= ch)
            begin
                c = 0;
                x++;
                if (x >= w)
                begin
                    x = 0;
                    y++;
                end
            end
            chan_pos = c;
            col_pos  = x;
            row_pos  = y;
            if (!emit)
                return;
            res.filtered  = PixW'(sum);
            res.frame_end = out_pos >= w * h * ch - 1;
            expected_filtered.push_back(res);
            if (res.frame_end)
            begin
                restart();
                frames_done++;
            end
            else
                out_pos++;
        endfunction

        function void check_filtered(logic [PixW-1:0] got, logic got_end);
            lap_result_t want;
            if (expected_filtered.size() == 0)
            begin
                errors++;
                if (errors <= MaxReports)
                    $display("%0t: word with nothing expected: filtered %0d frame_end %0b",
                             $time, got, got_end);
                return;
            end
            want = expected_filtered.pop_front();
            checked++;
            if (want.filtered == '0)
                pinned_low++;
            if (want.filtered == '1)
                pinned_high++;
            if (got !== want.filtered)
            begin
                errors++;
                if (errors <= MaxReports)
                    $display("%0t: filtered mismatch: expected %0d, actual %0d",
                             $time, want.filtered, got);
            end
            if (got_end !== want.frame_end)
            begin
                errors++;
                if (errors <= MaxReports)
                    $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                             $time, want.frame_end, got_end);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    lap3_in_if  pixel_in_ch ();
    lap3_out_if pixel_out_ch ();
    lap3_cfg_if cfg_ch ();

    edge_scoreboard sb = new();
    bit idle_in;
    bit idle_out;
    int stall_left;
    int unsigned cycle_count;

    laplacian_3x3_edge_filter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_in_ch),
        .pixel_out(pixel_out_ch),
        .cfg      (cfg_ch)
    );

    always #(HalfPeriod) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LimitCycles)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, LimitCycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            pixel_out_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            pixel_out_ch.ready <= 1'b0;
        end
        else if (idle_out && $urandom_range(0, 99) < 20)
        begin
            stall_left = gap_len() - 1;
            pixel_out_ch.ready <= 1'b0;
        end
        else
            pixel_out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && pixel_out_ch.valid && pixel_out_ch.ready)
            sb.check_filtered(pixel_out_ch.filtered, pixel_out_ch.frame_end);

    task automatic send_word(lap3_req_t req, logic [PixW-1:0] smp);
        if (idle_in && $urandom_range(0, 99) < 20)
        begin
            pixel_in_ch.valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        pixel_in_ch.valid    <= 1'b1;
        pixel_in_ch.req_type <= req;
        pixel_in_ch.sample   <= smp;
        do @(posedge clk); while (!pixel_in_ch.ready);
        sb.take_word(req, smp);
    endtask

    task automatic wait_drained();
        pixel_in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // words that give no result may still be in the pipe
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_register(lap3_cfg_idx_t idx, logic [CfgW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.load_register(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_image(int w, int h, int ch);
        write_register(CFG_IMAGE_WIDTH, CfgW'(w));
        write_register(CFG_IMAGE_HEIGHT, CfgW'(h));
        write_register(CFG_CHANNEL_COUNT, CfgW'(ch));
    endtask

    // well-formed frame shape with random content, plus some early flushes and late bytes
    task automatic send_random_word(output bit counted);
        lap3_req_t req;
        logic [PixW-1:0] smp;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            smp = $urandom_range(0, 1) ? '1 : '0;
        else
            smp = PixW'($urandom_range(0, 255));
        if (sb.in_image())
            req = (pick < 5) ? REQ_FLUSH : REQ_SAMPLE;
        else
            req = (pick < 8) ? REQ_SAMPLE : REQ_FLUSH;
        counted = !(sb.at_frame_start() && req == REQ_FLUSH);
        send_word(req, smp);
    endtask

    task automatic run_whole_frame();
        int start;
        bit counted;
        start = sb.frames_done;
        while (sb.frames_done == start)
            send_random_word(counted);
    endtask

    task automatic new_random_setting();
        int w, h, ch;
        lap3_cfg_idx_t idx;
        w  = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        h  = $urandom_range(1, 6);
        ch = $urandom_range(1, 4);
        if ($urandom_range(0, 19) == 0)
            h = 0;
        if ($urandom_range(0, 9) == 0)
            ch = $urandom_range(0, 1) ? 0 : $urandom_range(5, 7);
        idle_in  = $urandom_range(0, 3) != 0;
        idle_out = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 3) == 0)
        begin
            idx = lap3_cfg_idx_t'($urandom_range(0, 2));
            write_register(idx, (idx == CFG_IMAGE_WIDTH)  ? CfgW'(w) :
                                (idx == CFG_IMAGE_HEIGHT) ? CfgW'(h) : CfgW'(ch));
        end
        else
            set_image(w, h, ch);
    endtask

    initial
    begin
        int counted_words;
        int next_change;
        bit counted;
        rst_n                = 1'b0;
        pixel_in_ch.valid    = 1'b0;
        pixel_in_ch.req_type = REQ_SAMPLE;
        pixel_in_ch.sample   = '0;
        pixel_out_ch.ready   = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_IMAGE_WIDTH;
        cfg_ch.data          = '0;
        idle_in              = 1'b1;
        idle_out             = 1'b1;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 1024 wide, one channel; first results after a row and a pixel
        repeat (1100) send_random_word(counted);
        wait_drained();

        // 3x2 frame: dropped leading flush, extremes, early flush, byte past the end
        set_image(3, 2, 1);
        send_word(REQ_FLUSH, '1);
        send_word(REQ_SAMPLE, '1);
        send_word(REQ_SAMPLE, '0);
        send_word(REQ_SAMPLE, '1);
        send_word(REQ_FLUSH, '1);
        send_word(REQ_SAMPLE, '0);
        send_word(REQ_SAMPLE, '1);
        send_word(REQ_SAMPLE, PixW'(77));
        send_word(REQ_FLUSH, '0);
        send_word(REQ_FLUSH, '0);
        send_word(REQ_FLUSH, '0);
        wait_drained();
        // single pixel, then a flush after frame end which must be dropped
        write_register(CFG_IMAGE_WIDTH, CfgW'(1));
        write_register(CFG_IMAGE_HEIGHT, CfgW'(1));
        send_word(REQ_SAMPLE, '1);
        send_word(REQ_FLUSH, '0);
        send_word(REQ_FLUSH, '0);
        send_word(REQ_FLUSH, '1);
        wait_drained();

        // zero in every register clamps up to a single one-channel pixel
        set_image(0, 0, 0);
        run_whole_frame();
        wait_drained();
        // narrow column, channel count clamped to four, no idling on either side
        idle_in  = 1'b0;
        idle_out = 1'b0;
        set_image(1, 48, 7);
        run_whole_frame();
        wait_drained();
        idle_in  = 1'b1;
        idle_out = 1'b1;
        set_image(1, 1, 4);
        run_whole_frame();

        counted_words = 0;
        next_change   = 0;
        while (counted_words < RandomWords)
        begin
            if (counted_words >= next_change)
            begin
                wait_drained();
                new_random_setting();
                next_change = counted_words + $urandom_range(20, 60);
            end
            else if ($urandom_range(0, 499) == 0)
                wait_drained();
            send_random_word(counted);
            if (counted)
                counted_words++;
        end
        wait_drained();

        $display("covered: %0d words in (%0d flush ticks), %0d register writes, %0d frames closed",
                 sb.words_in, sb.flush_words, sb.writes, sb.frames_done);
        $display("covered: %0d results checked, %0d clamped low, %0d clamped high, %0d errors",
                 sb.checked, sb.pinned_low, sb.pinned_high, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
